FILE: rtl/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and constants for the coalescent log-likelihood gradient block.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int HeightW = 48;
  localparam int IndexW  = 9;
  localparam int SlotW   = 8;
  localparam int RegW    = 32;
  localparam int SumW    = 64;
  localparam int CfgIdxW = 2;

  localparam logic [IndexW-1:0] LineageMax = 9'd511;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LEAF_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INV_THETA  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOG_THETA  = 2'd2;

  // one datapath step per controller state
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_EVENT,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_COMBINE,
    DP_ACCUM,
    DP_GRAD,
    DP_T0,
    DP_T1,
    DP_T2,
    DP_T3,
    DP_T4,
    DP_T5,
    DP_T6,
    DP_T7,
    DP_TOTALS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } ccl_cmd_t;

  typedef struct packed {
    logic first_seen;
    logic internal;
    logic last;
    logic out_free;
  } ccl_status_t;

endpackage

FILE: rtl/ccl_ctrl.sv
// ----------------------------------------------------------------------------
// ccl_ctrl
// Sequencer for the event, gradient and totals steps of the datapath.
// ----------------------------------------------------------------------------
module ccl_ctrl
  import ccl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ccl_status_t st,
  output ccl_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_EVENT,
    S_MUL_LO,
    S_MUL_HI,
    S_COMBINE,
    S_ACCUM,
    S_GRAD,
    S_T0,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_T5,
    S_T6,
    S_T7,
    S_TOTALS
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = S_EVENT;
        end
      end
      S_EVENT: begin
        cmd.op = DP_EVENT;
        if (st.first_seen) begin
          state_next = S_MUL_LO;
        end else begin
          state_next = st.last ? S_T0 : S_IDLE;
        end
      end
      S_MUL_LO: begin
        cmd.op     = DP_MUL_LO;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op     = DP_MUL_HI;
        state_next = S_COMBINE;
      end
      S_COMBINE: begin
        cmd.op     = DP_COMBINE;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.op = DP_ACCUM;
        if (st.internal) begin
          state_next = S_GRAD;
        end else begin
          state_next = st.last ? S_T0 : S_IDLE;
        end
      end
      S_GRAD: begin
        if (st.out_free) begin
          cmd.op     = DP_GRAD;
          state_next = st.last ? S_T0 : S_IDLE;
        end
      end
      S_T0: begin
        cmd.op     = DP_T0;
        state_next = S_T1;
      end
      S_T1: begin
        cmd.op     = DP_T1;
        state_next = S_T2;
      end
      S_T2: begin
        cmd.op     = DP_T2;
        state_next = S_T3;
      end
      S_T3: begin
        cmd.op     = DP_T3;
        state_next = S_T4;
      end
      S_T4: begin
        cmd.op     = DP_T4;
        state_next = S_T5;
      end
      S_T5: begin
        cmd.op     = DP_T5;
        state_next = S_T6;
      end
      S_T6: begin
        cmd.op     = DP_T6;
        state_next = S_T7;
      end
      S_T7: begin
        cmd.op     = DP_T7;
        state_next = S_TOTALS;
      end
      S_TOTALS: begin
        if (st.out_free) begin
          cmd.op     = DP_TOTALS;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_event: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EVENT))
    else $error("accepted transaction did not start an event");

  a_totals_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_TOTALS) |=> in_ready)
    else $error("block not ready after totals");
`endif

endmodule

FILE: rtl/ccl_datapath.sv
// ----------------------------------------------------------------------------
// ccl_datapath
// Tree state, shared 33x33 multiplier, totals arithmetic and output register.
// ----------------------------------------------------------------------------
module ccl_datapath
  import ccl_pkg::*;
#(
  parameter int MAX_LEAVES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ccl_cmd_t                  cmd,
  output ccl_status_t               st,
  input  logic                      cfg_write,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [RegW-1:0]           cfg_data,
  input  logic [HeightW-1:0]        node_height,
  input  logic [IndexW-1:0]         node_index,
  input  logic                      last_event,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      result_kind,
  output logic [SlotW-1:0]          internal_slot,
  output logic signed [HeightW-1:0] height_gradient,
  output logic signed [SumW-1:0]    log_prob,
  output logic signed [SumW-1:0]    theta_gradient,
  output logic                      last_result
);

  localparam int LeafClampInt = (MAX_LEAVES > 511) ? 511 : MAX_LEAVES;
  localparam logic [IndexW-1:0] LeafClamp = IndexW'(LeafClampInt);
  localparam logic [SumW-1:0] U64Max = {SumW{1'b1}};
  localparam logic [SumW-1:0] S64Max = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] S64Min = {1'b1, {(SumW-1){1'b0}}};

  // configuration
  logic [IndexW-1:0] leaf_count;
  logic [RegW-1:0]   inv_theta;
  logic [RegW-1:0]   log_theta;

  // tree state
  logic [IndexW-1:0]  lineage_count;
  logic [HeightW-1:0] previous_height;
  logic [SumW-1:0]    weighted_interval_sum;
  logic               first_seen;

  // latched event
  logic [HeightW-1:0] ev_height;
  logic [IndexW-1:0]  ev_index;
  logic               ev_last;

  // working registers
  logic [HeightW-1:0] interval;
  logic [16:0]        pair_count;
  logic [48:0]        lo_keep;
  logic [SumW-1:0]    weighted_term;
  logic [RegW-1:0]    p_lo;
  logic [SumW-1:0]    p_hi;
  logic [SumW-1:0]    q_acc;
  logic [RegW-1:0]    q_lo;
  logic [SumW-1:0]    a_val;
  logic [SumW-1:0]    t_val;
  logic [SumW-1:0]    v_val;
  logic [39:0]        b_val;
  logic [SumW-1:0]    lp_val;

  // shared multiplier
  logic               mul_en;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  logic [IndexW-1:0] nm1;
  logic [IndexW-1:0] grad_factor;
  logic [17:0]       pair_raw;
  logic [65:0]       combine_sum;
  logic [64:0]       accum_sum;
  logic [64:0]       q_step;
  logic [SumW-1:0]   lp_limit;
  logic [SumW-1:0]   tg_diff;
  logic [SumW-1:0]   tg_val;
  logic              internal;

  assign internal       = (ev_index >= leaf_count);
  assign nm1            = (leaf_count == '0) ? '0 : leaf_count - IndexW'(1);
  assign grad_factor    = (lineage_count == '0) ? '0 : lineage_count - IndexW'(1);
  assign pair_raw       = 18'(lineage_count) * 18'(grad_factor);
  assign combine_sum    = {17'd0, lo_keep} + {prod[33:0], 32'd0};
  assign accum_sum      = {1'b0, weighted_interval_sum} + {1'b0, weighted_term};
  assign q_step         = {1'b0, q_acc} + {1'b0, prod[63:0]};
  // a + 2^63 wraps to a with its top bit flipped
  assign lp_limit       = {~a_val[SumW-1], a_val[SumW-2:0]};
  assign tg_diff        = v_val - {24'd0, b_val};
  assign tg_val         = (v_val >= {24'd0, b_val} && tg_diff[SumW-1]) ? S64Max : tg_diff;

  assign st.first_seen = first_seen;
  assign st.internal   = internal;
  assign st.last       = ev_last;
  assign st.out_free   = !out_valid || out_ready;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      DP_MUL_LO: begin
        mul_a = {16'd0, pair_count};
        mul_b = {1'b0, interval[31:0]};
      end
      DP_MUL_HI: begin
        mul_a = {16'd0, pair_count};
        mul_b = {17'd0, interval[47:32]};
      end
      DP_COMBINE: begin
        mul_a = {24'd0, grad_factor};
        mul_b = {1'b0, inv_theta};
      end
      DP_T0: begin
        mul_a = {1'b0, weighted_interval_sum[31:0]};
        mul_b = {1'b0, inv_theta};
      end
      DP_T1: begin
        mul_a = {1'b0, weighted_interval_sum[63:32]};
        mul_b = {1'b0, inv_theta};
      end
      DP_T2: begin
        mul_a = {24'd0, nm1};
        mul_b = {log_theta[RegW-1], log_theta};
      end
      DP_T3: begin
        mul_a = {1'b0, p_lo};
        mul_b = {1'b0, inv_theta};
      end
      DP_T4: begin
        mul_a = {1'b0, p_hi[31:0]};
        mul_b = {1'b0, inv_theta};
      end
      DP_T5: begin
        mul_a = {1'b0, p_hi[63:32]};
        mul_b = {1'b0, inv_theta};
      end
      DP_T6: begin
        mul_a = {24'd0, nm1};
        mul_b = {1'b0, inv_theta};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 66'(mul_a) * 66'(mul_b);
    end
  end

  // configuration and tree state
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count            <= IndexW'(2);
      inv_theta             <= RegW'(65536);
      log_theta             <= '0;
      lineage_count         <= IndexW'(1);
      previous_height       <= '0;
      weighted_interval_sum <= '0;
      first_seen            <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_LEAF_COUNT: begin
            leaf_count <= (cfg_data[IndexW-1:0] > LeafClamp) ? LeafClamp
                                                             : cfg_data[IndexW-1:0];
          end
          CFG_INV_THETA: inv_theta <= cfg_data;
          CFG_LOG_THETA: log_theta <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        DP_EVENT: begin
          previous_height <= ev_height;
          first_seen      <= 1'b1;
        end
        DP_ACCUM: begin
          weighted_interval_sum <= accum_sum[SumW] ? U64Max : accum_sum[SumW-1:0];
          if (internal) begin
            if (lineage_count != '0) begin
              lineage_count <= lineage_count - IndexW'(1);
            end
          end else if (lineage_count != LineageMax) begin
            lineage_count <= lineage_count + IndexW'(1);
          end
        end
        DP_TOTALS: begin
          lineage_count         <= IndexW'(1);
          previous_height       <= '0;
          weighted_interval_sum <= '0;
          first_seen            <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        ev_height <= node_height;
        ev_index  <= node_index;
        ev_last   <= last_event;
      end
      DP_EVENT: begin
        interval   <= (ev_height > previous_height) ? ev_height - previous_height : '0;
        pair_count <= pair_raw[17:1];
      end
      DP_MUL_HI: begin
        lo_keep <= prod[48:0];
      end
      DP_COMBINE: begin
        weighted_term <= (combine_sum[65:64] != 2'd0) ? U64Max : combine_sum[63:0];
      end
      DP_T1: begin
        p_lo <= prod[31:0];
        p_hi <= {32'd0, prod[63:32]};
      end
      DP_T2: begin
        p_hi <= p_hi + prod[63:0];
      end
      DP_T3: begin
        a_val <= SumW'(0) - prod[63:0];
        // floor(S*inv / 2^16), saturated
        t_val <= (p_hi[63:48] != 16'd0) ? U64Max : {p_hi[47:0], p_lo[31:16]};
      end
      DP_T4: begin
        q_acc <= {32'd0, prod[63:32]};
      end
      DP_T5: begin
        q_lo  <= q_step[31:0];
        q_acc <= {31'd0, q_step[64:32]};
      end
      DP_T6: begin
        q_acc <= q_acc + prod[63:0];
      end
      DP_T7: begin
        b_val  <= prod[39:0];
        // floor(S*inv^2 / 2^32), saturated
        v_val  <= (q_acc[63:32] != 32'd0) ? U64Max : {q_acc[31:0], q_lo};
        lp_val <= (t_val > lp_limit) ? S64Min : a_val - t_val;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_GRAD || cmd.op == DP_TOTALS) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_GRAD) begin
      result_kind     <= 1'b0;
      internal_slot   <= SlotW'(ev_index - leaf_count);
      height_gradient <= HeightW'(0) - prod[HeightW-1:0];
      log_prob        <= '0;
      theta_gradient  <= '0;
      last_result     <= 1'b0;
    end else if (cmd.op == DP_TOTALS) begin
      result_kind     <= 1'b1;
      internal_slot   <= '0;
      height_gradient <= '0;
      log_prob        <= lp_val;
      theta_gradient  <= tg_val;
      last_result     <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_GRAD || cmd.op == DP_TOTALS) |-> (!out_valid || out_ready))
    else $error("output register loaded while a transaction is pending");

  a_tree_cleared: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_TOTALS) |=> (!first_seen && lineage_count == IndexW'(1)
                               && weighted_interval_sum == '0))
    else $error("tree state not cleared after totals");

  a_kind_matches_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == last_result))
    else $error("totals result without last flag");
`endif

endmodule

FILE: rtl/constant_coalescent_loglik_grad.sv
// ----------------------------------------------------------------------------
// constant_coalescent_loglik_grad
// Constant-size coalescent log-likelihood with height and theta gradients.
// ----------------------------------------------------------------------------
// Tree events enter on the in_valid/in_ready channel in ascending height
// order, one transaction per node; last_event marks the root. Results leave
// on out_valid/out_ready: a height gradient for each internal node after the
// first event, and on the root one more transaction with log_prob and
// theta_gradient (result_kind and last_result high).
// A new event is taken only once the last is done. The first event of a
// tree only opens it; a later event runs the interval product and the
// accumulation steps, an internal node adds a gradient step and the root
// adds the totals steps. The one shared 33x33 multiplier serves the interval
// product, the gradient and seven partial products of the totals, one a cycle.
// The output register holds a finished result while the next transaction is
// taken; when the receiver stalls with a result still held, the block waits
// before loading the next one. Reset clears the tree state and loads the
// configuration defaults (two leaves, theta of one, log theta of zero).
// Configuration writes via cfg_write/cfg_index/cfg_data are for idle periods.
module constant_coalescent_loglik_grad
  import ccl_pkg::*;
#(
  parameter int MAX_LEAVES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [RegW-1:0]           cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [HeightW-1:0]        node_height,
  input  logic [IndexW-1:0]         node_index,
  input  logic                      last_event,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      result_kind,
  output logic [SlotW-1:0]          internal_slot,
  output logic signed [HeightW-1:0] height_gradient,
  output logic signed [SumW-1:0]    log_prob,
  output logic signed [SumW-1:0]    theta_gradient,
  output logic                      last_result
);

  ccl_cmd_t    cmd;
  ccl_status_t st;

  ccl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  ccl_datapath #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .node_height     (node_height),
    .node_index      (node_index),
    .last_event      (last_event),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .internal_slot   (internal_slot),
    .height_gradient (height_gradient),
    .log_prob        (log_prob),
    .theta_gradient  (theta_gradient),
    .last_result     (last_result)
  );

endmodule

FILE: tb/tb_constant_coalescent_loglik_grad.sv
// ----------------------------------------------------------------------------
// tb_constant_coalescent_loglik_grad
// Self-checking bench for the coalescent log-likelihood gradient block.
// Events are driven as ascending tree sequences and as noise. A local copy of
// the lineage count, interval sum and registers predicts every gradient and
// totals result, checked field by field as each result transaction arrives.
// ----------------------------------------------------------------------------
module tb_constant_coalescent_loglik_grad;
  timeunit 1ns;
  timeprecision 1ps;
  import ccl_pkg::*;

  localparam int LeafLimit   = 256;
  localparam int SettleCycles = 24;
  localparam int IdleLimit   = 3000;
  localparam logic [SumW-1:0] SumMax    = '1;
  localparam logic [SumW-1:0] PosMax    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SumW-1:0] NegMax    = 64'h8000_0000_0000_0000;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_t;

  typedef struct packed {
    logic               kind;
    logic [SlotW-1:0]   slot;
    logic [HeightW-1:0] grad;
    logic [SumW-1:0]    logp;
    logic [SumW-1:0]    dtheta;
    logic               last;
  } tree_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [RegW-1:0]           cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [HeightW-1:0]        node_height = '0;
  logic [IndexW-1:0]         node_index = '0;
  logic                      last_event = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      result_kind;
  logic [SlotW-1:0]          internal_slot;
  logic signed [HeightW-1:0] height_gradient;
  logic signed [SumW-1:0]    log_prob;
  logic signed [SumW-1:0]    theta_gradient;
  logic                      last_result;

  // register copies
  logic [IndexW-1:0] cfg_leaves = 9'd2;
  logic [RegW-1:0]   cfg_inv = 32'h0001_0000;
  logic [RegW-1:0]   cfg_log = '0;

  // tree state copies
  logic [IndexW-1:0]  lineages = 9'd1;
  logic [HeightW-1:0] last_height = '0;
  logic [SumW-1:0]    interval_sum = '0;
  logic               tree_open = 1'b0;

  tree_result_t due_results[$];

  int failures = 0;
  int events_sent = 0;
  int results_seen = 0;
  int trees_scored = 0;
  int settings_written = 0;
  int burst_left = 0;
  int stall_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;

  constant_coalescent_loglik_grad #(
    .MAX_LEAVES(LeafLimit)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .node_height(node_height),
    .node_index(node_index),
    .last_event(last_event),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .internal_slot(internal_slot),
    .height_gradient(height_gradient),
    .log_prob(log_prob),
    .theta_gradient(theta_gradient),
    .last_result(last_result)
  );

  always #5 clk = ~clk;

  // interval accumulation, height gradient and end-of-tree totals
  task automatic advance_coalescent(input logic [HeightW-1:0] h, input logic [IndexW-1:0] idx,
                                    input logic last);
    logic [HeightW-1:0] span;
    logic [127:0]       pairs, prod, slope, p1, p2;
    logic [SumW:0]      acc;
    logic [IndexW-1:0]  offset;
    logic [SumW-1:0]    nm1, t_term, v_term, a_term, lim, base, excess, lt64;
    tree_result_t       r;
    if (!tree_open) begin
      // first event only opens the tree
      tree_open = 1'b1;
      last_height = h;
    end else begin
      span = (h > last_height) ? h - last_height : '0;
      pairs = 128'(lineages);
      pairs = (pairs * (pairs - 128'(lineages != '0))) >> 1;
      prod = pairs * 128'(span);
      acc = {1'b0, interval_sum} + {1'b0, (prod[127:64] != '0) ? SumMax : prod[63:0]};
      interval_sum = acc[SumW] ? SumMax : acc[SumW-1:0];
      last_height = h;
      if (idx >= cfg_leaves) begin
        slope = 128'((lineages != '0) ? lineages - 9'd1 : 9'd0) * 128'(cfg_inv);
        offset = idx - cfg_leaves;
        r = '0;
        r.slot = offset[SlotW-1:0];
        r.grad = -slope[HeightW-1:0];
        due_results.push_back(r);
        if (lineages != '0) lineages = lineages - 9'd1;
      end else if (lineages != LineageMax) begin
        lineages = lineages + 9'd1;
      end
    end
    if (last) begin
      nm1 = (cfg_leaves != '0) ? 64'(cfg_leaves) - 64'd1 : '0;
      p1 = 128'(interval_sum) * 128'(cfg_inv);
      t_term = (p1[127:80] != '0) ? SumMax : p1[79:16];
      p2 = p1 * 128'(cfg_inv);
      v_term = (p2[127:96] != '0) ? SumMax : p2[95:32];
      lt64 = {{32{cfg_log[31]}}, cfg_log};
      a_term = -(nm1 * lt64);
      // distance from a_term down to the most negative value
      lim = a_term + NegMax;
      r = '0;
      r.kind = 1'b1;
      r.last = 1'b1;
      r.logp = (t_term > lim) ? NegMax : a_term - t_term;
      base = nm1 * 64'(cfg_inv);
      if (v_term >= base) begin
        excess = v_term - base;
        r.dtheta = (excess > PosMax) ? PosMax : excess;
      end else begin
        r.dtheta = -(base - v_term);
      end
      due_results.push_back(r);
      lineages = 9'd1;
      last_height = '0;
      interval_sum = '0;
      tree_open = 1'b0;
    end
  endtask

  task automatic send_event(input logic [HeightW-1:0] h, input logic [IndexW-1:0] idx,
                            input logic last);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    node_height <= h;
    node_index <= idx;
    last_event <= last;
    do @(posedge clk); while (!in_ready);
    advance_coalescent(h, idx, last);
    events_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // hold the sender until every result is back and the block has gone quiet
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic program_regs(input int n, input logic [RegW-1:0] inv,
                              input logic [RegW-1:0] lth);
    drain_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_LEAF_COUNT;
    cfg_data <= 32'(n);
    @(negedge clk);
    cfg_index <= CFG_INV_THETA;
    cfg_data <= inv;
    @(negedge clk);
    cfg_index <= CFG_LOG_THETA;
    cfg_data <= lth;
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_leaves = (n > LeafLimit) ? 9'(LeafLimit) : 9'(n);
    cfg_inv = inv;
    cfg_log = lth;
    settings_written++;
  endtask

  function automatic logic [HeightW-1:0] next_height(input logic [HeightW-1:0] h);
    logic [HeightW:0]   sum;
    logic [HeightW-1:0] step;
    case ($urandom_range(0, 7))
      0, 1:    step = '0;
      2, 3, 4: step = 48'($urandom_range(1, 32'h0001_0000));
      5, 6:    step = 48'($urandom);
      default: step = {16'($urandom), 32'($urandom)} >> $urandom_range(0, 16);
    endcase
    sum = {1'b0, h} + {1'b0, step};
    return sum[HeightW] ? '1 : sum[HeightW-1:0];
  endfunction

  // well-formed tree: one leaf event per leaf (random leaf index), internal nodes while two or more live
  task automatic send_tree();
    int left, live, hi;
    logic [HeightW-1:0] h;
    logic [IndexW-1:0]  idx;
    logic               done;
    left = cfg_leaves;
    live = 0;
    hi = 2 * cfg_leaves - 2;
    done = 1'b0;
    h = ($urandom_range(0, 3) == 0) ? '0 : 48'($urandom) >> $urandom_range(0, 31);
    while (!done) begin
      h = next_height(h);
      if (left > 0 && (live < 2 || $urandom_range(0, 2) != 0)) begin
        idx = 9'($urandom_range(0, cfg_leaves - 1));
        left--;
        live++;
      end else begin
        idx = 9'($urandom_range(cfg_leaves, hi));
        live--;
        done = (left == 0 && live == 1);
      end
      send_event(h, idx, done);
    end
  endtask

  task automatic test_directed();
    // reset registers: two leaves, theta of one, log theta of zero
    send_event('0, 9'd0, 1'b0);
    send_event(48'h1_0000, 9'd1, 1'b0);
    send_event(48'h3_0000, 9'd2, 1'b1);
    // root on its own: totals only
    send_event('1, 9'd510, 1'b1);
    // tree opened by an internal index, lineages run dry, height goes down
    send_event(48'd5, 9'd3, 1'b0);
    send_event(48'd10, 9'd3, 1'b0);
    send_event(48'd8, 9'd4, 1'b0);
    send_event(48'd20, 9'd0, 1'b0);
    send_event('1, 9'd1, 1'b0);
    send_event('1, 9'd2, 1'b1);
    program_regs(LeafLimit, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_event('0, 9'd0, 1'b0);
    send_event('0, 9'd255, 1'b0);
    send_event('1, 9'd510, 1'b1);
    program_regs(3, 32'd1, 32'h8000_0000);
    send_event(48'd100, 9'd2, 1'b0);
    send_event(48'd200, 9'd0, 1'b0);
    send_event(48'd300, 9'd4, 1'b0);
    send_event(48'd400, 9'd1, 1'b0);
    send_event(48'd500, 9'd3, 1'b1);
  endtask

  task automatic test_random_trees();
    int phase, n, stop_at;
    logic [RegW-1:0] inv, lth;
    for (phase = 0; phase < 10; phase++) begin
      n = (phase % 3 == 0) ? 2 : $urandom_range(3, (phase < 8) ? 12 : 40);
      case (phase % 4)
        0:       inv = 32'd1;
        1:       inv = 32'hFFFF_FFFF;
        2:       inv = $urandom_range(1, 32'hFFFF_FFFF);
        default: inv = $urandom_range(32'h0000_1000, 32'h0010_0000);
      endcase
      case (phase % 5)
        0:       lth = 32'h8000_0000;
        1:       lth = 32'h7FFF_FFFF;
        2:       lth = '0;
        default: lth = $urandom;
      endcase
      program_regs(n, inv, lth);
      stop_at = events_sent + 100;
      while (events_sent < stop_at) begin
        send_tree();
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end
  endtask

  // push lineages past their ceiling, then one huge interval saturates the sum
  task automatic test_lineage_bounds();
    logic [HeightW-1:0] h;
    program_regs(LeafLimit, 32'hFFFF_FFFF, 32'h8000_0000);
    h = '0;
    send_event(h, 9'd0, 1'b0);
    repeat (515) begin
      h = h + 48'($urandom_range(0, 1));
      send_event(h, 9'($urandom_range(0, LeafLimit - 1)), 1'b0);
    end
    send_event('1, 9'd17, 1'b0);
    repeat (3) send_event('1, 9'($urandom_range(LeafLimit, 510)), 1'b0);
    send_event('1, 9'd300, 1'b1);
  endtask

  task automatic test_noise();
    logic [HeightW-1:0] h;
    program_regs($urandom_range(2, LeafLimit), $urandom_range(1, 32'hFFFF_FFFF), $urandom);
    h = '0;
    repeat (160) begin
      h = ($urandom_range(0, 1) == 0) ? {16'($urandom), 32'($urandom)} : next_height(h);
      send_event(h, 9'($urandom_range(0, 510)), $urandom_range(0, 11) == 0);
    end
    send_event({16'($urandom), 32'($urandom)}, 9'($urandom_range(0, 510)), 1'b1);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    tree_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result transaction with none expected: kind %0d slot %0d",
               result_kind, internal_slot);
        failures++;
      end else begin
        want = due_results.pop_front();
        results_seen++;
        if (want.last) trees_scored++;
        check_field("result_kind", 64'(want.kind), 64'(result_kind));
        check_field("internal_slot", 64'(want.slot), 64'(internal_slot));
        check_field("height_gradient", 64'(want.grad), 64'($unsigned(height_gradient)));
        check_field("log_prob", want.logp, $unsigned(log_prob));
        check_field("theta_gradient", want.dtheta, $unsigned(theta_gradient));
        check_field("last_result", 64'(want.last), 64'(last_result));
      end
    end
  end

  // receiver backpressure in stretches of differing character
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 50);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_trees();
    test_lineage_bounds();
    test_noise();
    drain_results();
    $display("%0d events sent, %0d results checked over %0d trees",
             events_sent, results_seen, trees_scored);
    $display("%0d register settings, leaf count and theta extremes included",
             settings_written);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ccl_pkg.sv
rtl/ccl_ctrl.sv
rtl/ccl_datapath.sv
rtl/constant_coalescent_loglik_grad.sv
tb/tb_constant_coalescent_loglik_grad.sv
